FILE: design/wlpgm_pkg.sv
// Package: shared constants and types for the wear-leveled pin group modulator.
package wlpgm_pkg;
	localparam int unsigned MAX_PINS_DEF = 16;
	localparam int unsigned DUTY_RES_DEF = 1024;
	localparam int unsigned TIME_WIDTH_DEF = 32;

	localparam int unsigned DUTY_W = 16;
	localparam int unsigned DT_W = 16;
	localparam int unsigned STATES_W = 16;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIN_COUNT = 2'd0,
		REG_IDLE_MIN  = 2'd1,
		REG_BUSY_MIN  = 2'd2,
		REG_SWAP_PER  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [DUTY_W-1:0] requested_duty;
		logic [DT_W-1:0]          elapsed_ticks;
	} req_t;

	typedef struct packed {
		logic [STATES_W-1:0] pin_states;
		logic [COUNT_W-1:0]  on_count;
	} rsp_t;
endpackage

FILE: design/wlpgm_if.sv
// Interfaces: valid/ready channels for requests and results.
interface wlpgm_req_if;
	import wlpgm_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface wlpgm_rsp_if;
	import wlpgm_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/wear_leveled_pin_group_modulator.sv
// Wear-leveled pin group modulator: top level with per-pin counter memories.
//
// Usage: each request on req (requested_duty, elapsed_ticks) is one control call.
// The block drives floor(duty*pin_count/DUTY_RESOLUTION) pins on, choosing them
// so that accumulated on-time stays even, and returns one result on rsp
// (pin_states, on_count) per request. Configuration must be written through
// cfg_we/cfg_idx/cfg_data only while idle; the block itself does not enforce this.
// Per-pin on-time and time-in-state counters live in two synchronous memories
// (one address per cycle, read data registered).
// Every pass is a scan over the pins through those memories: an update pass,
// a swap-selection scan, and one selection scan per pin switched.
// Steps, with N pins in use: an update pass over the N pins, a swap decision,
// a swap scan when the swap timer runs out, a round start, a selection scan per
// switched pin, and registering of the result.
// One request is in work at a time; the memory port sets the rate.
// Reset: all pins off, counters clear; a clearing pass over all MAX_PINS addresses
// sweeps both memories before the first request is accepted.
// A stalled receiver holds the result in the output register; the next request
// is accepted only once that result has been taken.
module wear_leveled_pin_group_modulator #(
	parameter int unsigned MAX_PINS = wlpgm_pkg::MAX_PINS_DEF,
	parameter int unsigned DUTY_RESOLUTION = wlpgm_pkg::DUTY_RES_DEF,
	parameter int unsigned TIME_WIDTH = wlpgm_pkg::TIME_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	wlpgm_req_if.sink req,
	wlpgm_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic [wlpgm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [wlpgm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wlpgm_pkg::*;

	localparam int unsigned AW = (MAX_PINS > 1) ? $clog2(MAX_PINS) : 1;
	localparam int unsigned CW = $clog2(MAX_PINS + 1);
	localparam int unsigned TW = TIME_WIDTH;
	localparam logic [TW-1:0] TMAX = {TW{1'b1}};
	localparam int unsigned PROD_W = DUTY_W + CW;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_UPD_RD, S_UPD_WR, S_SWAP_DEC, S_SCAN, S_SCAN2,
		S_APPLY, S_APPLY2, S_NEXT, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		M_SWAP, M_ON, M_OFF
	} mode_t;

	// Configuration registers
	logic [COUNT_W-1:0] pin_count_q;
	logic [TW-1:0] idle_min_q, busy_min_q, swap_per_q;

	// State memories
	logic [TW-1:0] tot_mem [MAX_PINS];
	logic [TW-1:0] tis_mem [MAX_PINS];
	logic [TW-1:0] tot_rd_q, tis_rd_q;
	logic [AW-1:0] mem_addr;
	logic mem_we_tot, mem_we_tis;
	logic [TW-1:0] tot_wd, tis_wd;

	// Control
	state_t state_q;
	mode_t mode_q;
	logic [MAX_PINS-1:0] pin_on_q;
	logic [CW-1:0] busy_q, target_q, n_q;
	logic [TW-1:0] swap_timer_q;
	logic started_q;
	logic [DT_W-1:0] dt_q;
	logic signed [DUTY_W-1:0] duty_q;
	logic [CW:0] ptr_q;
	logic rd_pend_q;
	logic [AW-1:0] rd_idx_q;
	// Scan candidates: primary (qualified, by total) and fallback (by time in state)
	logic pv_q, fv_q, lv_q, hv_q;
	logic [AW-1:0] pi_q, fi_q, li_q, hi_q;
	logic [TW-1:0] ptot_q, ftis_q, ltot_q, htot_q, ltis_q, htis_q;
	logic out_v_q;
	rsp_t out_q;
	logic [PROD_W-1:0] prod_s1;

	// Memory access: one port, one address per cycle
	always_ff @(posedge clk) begin
		if (mem_we_tot) tot_mem[mem_addr] <= tot_wd;
		if (mem_we_tis) tis_mem[mem_addr] <= tis_wd;
		tot_rd_q <= tot_mem[mem_addr];
		tis_rd_q <= tis_mem[mem_addr];
	end

	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [DT_W-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + (TW+1)'(b);
		return s[TW] ? TMAX : s[TW-1:0];
	endfunction

	logic [AW-1:0] ptr_a;
	assign ptr_a = ptr_q[AW-1:0];
	logic scan_end;
	assign scan_end = (ptr_q >= (CW+1)'(n_q));
	logic want_on;
	assign want_on = (mode_q != M_ON);  // state looked for in a scan
	logic [TW-1:0] min_sel;
	assign min_sel = want_on ? busy_min_q : idle_min_q;
	logic rd_in_state;
	assign rd_in_state = (pin_on_q[rd_idx_q] == want_on);

	// Clamped duty and target product
	logic [DUTY_W-1:0] duty_c;
	always_comb begin
		if (duty_q < 0) duty_c = '0;
		else if (duty_q > DUTY_W'(DUTY_RESOLUTION)) duty_c = DUTY_W'(DUTY_RESOLUTION);
		else duty_c = duty_q;
	end

	// Target count: largest k with k*DUTY_RESOLUTION not above the product
	logic [CW-1:0] target_c;
	always_comb begin
		target_c = '0;
		for (int unsigned k = 1; k <= MAX_PINS; k++) begin
			if (32'(prod_s1) >= k * DUTY_RESOLUTION) target_c = CW'(k);
		end
	end

	// Memory address and write data per state
	always_comb begin
		mem_addr = ptr_a;
		mem_we_tot = 1'b0;
		mem_we_tis = 1'b0;
		tot_wd = '0;
		tis_wd = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we_tot = 1'b1;
				mem_we_tis = 1'b1;
			end
			S_UPD_WR: begin
				mem_addr = rd_idx_q;
				mem_we_tot = 1'b1;
				mem_we_tis = 1'b1;
				tot_wd = pin_on_q[rd_idx_q] ? sat_add(tot_rd_q, dt_q) : tot_rd_q;
				tis_wd = sat_add(tis_rd_q, dt_q);
			end
			S_APPLY: begin
				mem_addr = (mode_q == M_OFF) ? hi_q : li_q;
				mem_we_tis = 1'b1;
			end
			S_APPLY2: begin
				mem_addr = hi_q;
				mem_we_tis = 1'b1;
			end
			default: ;
		endcase
	end

	assign req.ready = (state_q == S_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			mode_q <= M_SWAP;
			pin_count_q <= COUNT_W'(16);
			idle_min_q <= '0;
			busy_min_q <= '0;
			swap_per_q <= TW'(1000);
			pin_on_q <= '0;
			busy_q <= '0;
			swap_timer_q <= '0;
			started_q <= 1'b0;
			ptr_q <= '0;
			rd_pend_q <= 1'b0;
			out_v_q <= 1'b0;
			pv_q <= 1'b0; fv_q <= 1'b0; lv_q <= 1'b0; hv_q <= 1'b0;
		end else begin
			// Configuration writes
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_PIN_COUNT: pin_count_q <= cfg_data[COUNT_W-1:0];
					REG_IDLE_MIN: idle_min_q <= TW'(cfg_data);
					REG_BUSY_MIN: busy_min_q <= TW'(cfg_data);
					REG_SWAP_PER: swap_per_q <= TW'(cfg_data);
					default: ;
				endcase
			end
			if (out_v_q && rsp.ready) out_v_q <= 1'b0;
			unique case (state_q)
				// Sweep both memories after reset
				S_CLEAR: begin
					if (ptr_q == (CW+1)'(MAX_PINS - 1)) begin
						ptr_q <= '0;
						state_q <= S_IDLE;
					end else ptr_q <= ptr_q + 1'b1;
				end
				// Take a request
				S_IDLE: begin
					if (req.valid && !out_v_q) begin
						duty_q <= req.payload.requested_duty;
						if (pin_count_q == '0) begin
							out_q.pin_states <= STATES_W'(pin_on_q);
							out_q.on_count <= COUNT_W'(busy_q);
							out_v_q <= 1'b1;
						end else begin
							n_q <= (32'(pin_count_q) > MAX_PINS) ? CW'(MAX_PINS) : CW'(pin_count_q);
							dt_q <= started_q ? req.payload.elapsed_ticks : '0;
							started_q <= 1'b1;
							ptr_q <= '0;
							rd_pend_q <= 1'b0;
							state_q <= S_UPD_RD;
						end
					end
				end
				// Update pass: read pin, then write the saturated sums
				S_UPD_RD: begin
					prod_s1 <= PROD_W'(duty_c) * PROD_W'(n_q);
					if (scan_end) begin
						swap_timer_q <= sat_add(swap_timer_q, dt_q);
						state_q <= S_SWAP_DEC;
					end else begin
						rd_idx_q <= ptr_a;
						state_q <= S_UPD_WR;
					end
				end
				S_UPD_WR: begin
					ptr_q <= ptr_q + 1'b1;
					state_q <= S_UPD_RD;
				end
				// Decide on swap; set the target count
				S_SWAP_DEC: begin
					target_q <= target_c;
					ptr_q <= '0;
					rd_pend_q <= 1'b0;
					pv_q <= 1'b0; fv_q <= 1'b0; lv_q <= 1'b0; hv_q <= 1'b0;
					if (swap_timer_q > swap_per_q) begin
						swap_timer_q <= '0;
						mode_q <= M_SWAP;
						state_q <= S_SCAN;
					end else state_q <= S_NEXT;
				end
				// Scan: issue reads, fold the registered read data
				S_SCAN: begin
					if (rd_pend_q) begin
						if (mode_q == M_SWAP) begin
							if (!pin_on_q[rd_idx_q]) begin
								if (!lv_q || tot_rd_q < ltot_q) begin
									lv_q <= 1'b1; li_q <= rd_idx_q;
									ltot_q <= tot_rd_q; ltis_q <= tis_rd_q;
								end
							end else if (!hv_q || tot_rd_q > htot_q) begin
								hv_q <= 1'b1; hi_q <= rd_idx_q;
								htot_q <= tot_rd_q; htis_q <= tis_rd_q;
							end
						end else if (rd_in_state) begin
							if (tis_rd_q > min_sel && (!pv_q ||
							    (want_on ? tot_rd_q > ptot_q : tot_rd_q < ptot_q))) begin
								pv_q <= 1'b1; pi_q <= rd_idx_q; ptot_q <= tot_rd_q;
							end
							if (!fv_q || tis_rd_q > ftis_q) begin
								fv_q <= 1'b1; fi_q <= rd_idx_q; ftis_q <= tis_rd_q;
							end
						end
					end
					if (scan_end) begin
						rd_pend_q <= 1'b0;
						state_q <= S_SCAN2;
					end else begin
						rd_pend_q <= 1'b1;
						rd_idx_q <= ptr_a;
						ptr_q <= ptr_q + 1'b1;
					end
				end
				// Resolve the scan into pins to switch
				S_SCAN2: begin
					if (mode_q == M_SWAP) begin
						if (lv_q && hv_q && ltis_q > idle_min_q && htis_q > busy_min_q) begin
							pin_on_q[li_q] <= 1'b1;
							pin_on_q[hi_q] <= 1'b0;
							state_q <= S_APPLY;
						end else state_q <= S_NEXT;
					end else if (pv_q || fv_q) begin
						if (mode_q == M_ON) begin
							li_q <= pv_q ? pi_q : fi_q;
							pin_on_q[pv_q ? pi_q : fi_q] <= 1'b1;
							busy_q <= busy_q + 1'b1;
						end else begin
							hi_q <= pv_q ? pi_q : fi_q;
							pin_on_q[pv_q ? pi_q : fi_q] <= 1'b0;
							busy_q <= busy_q - 1'b1;
						end
						state_q <= S_APPLY;
					end else begin
						// No pin in the wanted state: later rounds find none either
						target_q <= busy_q;
						state_q <= S_NEXT;
					end
				end
				// Clear time in state of switched pins
				S_APPLY: state_q <= (mode_q == M_SWAP) ? S_APPLY2 : S_NEXT;
				S_APPLY2: state_q <= S_NEXT;
				// Start the next switching round or finish
				S_NEXT: begin
					ptr_q <= '0;
					rd_pend_q <= 1'b0;
					pv_q <= 1'b0; fv_q <= 1'b0; lv_q <= 1'b0; hv_q <= 1'b0;
					if (target_q > busy_q) begin
						mode_q <= M_ON;
						state_q <= S_SCAN;
					end else if (target_q < busy_q) begin
						mode_q <= M_OFF;
						state_q <= S_SCAN;
					end else state_q <= S_DONE;
				end
				S_DONE: begin
					out_q.pin_states <= STATES_W'(pin_on_q);
					out_q.on_count <= COUNT_W'(busy_q);
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks
	a_busy_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q <= CW'(MAX_PINS)) else $error("busy count out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> !out_v_q) else $error("accept over pending result");
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (32'(busy_q) == 32'($countones(pin_on_q))))
		else $error("busy count disagrees with pin bits");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !rsp.ready) |=> (out_v_q && $stable(out_q)))
		else $error("result dropped under stall");
endmodule
